// ===== src/tlmc_pkg.sv =====
package tlmc_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned CfgWidth      = 16;
  localparam int unsigned CfgIdxWidth   = 2;

  localparam logic [CfgWidth-1:0] RedTicksRst    = 16'd4000;
  localparam logic [CfgWidth-1:0] YellowTicksRst = 16'd2400;
  localparam logic [CfgWidth-1:0] GreenTicksRst  = 16'd8000;
  localparam logic [CfgWidth-1:0] BlinkTicksRst  = 16'd800;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] REG_RED    = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_YELLOW = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_GREEN  = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_BLINK  = 2'd3;

  // item kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_RX   = 2'd1;
  localparam logic [1:0] KIND_BTN  = 2'd2;

  // modes
  localparam logic [1:0] MODE_RED   = 2'd1;
  localparam logic [1:0] MODE_BLINK = 2'd2;
  localparam logic [1:0] MODE_CYCLE = 2'd3;

  // phases
  localparam logic [1:0] PH_RED    = 2'd0;
  localparam logic [1:0] PH_YELLOW = 2'd1;
  localparam logic [1:0] PH_GREEN  = 2'd2;
  localparam logic [1:0] PH_LIT    = 2'd0;
  localparam logic [1:0] PH_DARK   = 2'd1;

  localparam logic [1:0] BTN_NONE = 2'd3;

  // ascii codes
  localparam logic [7:0] CH_LOCAL   = 8'h41; // A
  localparam logic [7:0] CH_REMOTE  = 8'h55; // U
  localparam logic [7:0] CH_ACK_LOC = 8'h45; // E
  localparam logic [7:0] CH_ACK_REM = 8'h44; // D
  localparam logic [7:0] CH_DIG_LO  = 8'h31; // 1
  localparam logic [7:0] CH_DIG_HI  = 8'h33; // 3
  localparam logic [7:0] CH_ACK_RED = 8'h21; // !
  localparam logic [7:0] CH_ACK_BLK = 8'h40; // @
  localparam logic [7:0] CH_ACK_CYC = 8'h23; // #

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [1:0] button_index;
  } tlmc_item_t;

  typedef struct packed {
    logic       lamp_red;
    logic       lamp_yellow;
    logic       lamp_green;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } tlmc_result_t;

  function automatic logic [7:0] mode_reply(input logic [1:0] mode);
    logic [7:0] r;
    case (mode)
      MODE_RED:   r = CH_ACK_RED;
      MODE_BLINK: r = CH_ACK_BLK;
      MODE_CYCLE: r = CH_ACK_CYC;
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== src/tlmc_engine.sv =====
module tlmc_engine
  import tlmc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   fire_i,
  input  tlmc_item_t             item_i,
  output tlmc_result_t           result_o
);

  localparam int unsigned CmpWidth =
      ((COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth) + 1;

  logic [CfgWidth-1:0] red_ticks_q, yellow_ticks_q, green_ticks_q, blink_ticks_q;
  logic [1:0] mode_q, mode_d;
  logic       local_q, local_d;
  logic [1:0] phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

  logic [CmpWidth-1:0] cnt_nxt, len_ext, cmax_ext;
  logic [CfgWidth-1:0] len;
  logic       req_valid;
  logic [1:0] req_mode;
  logic       tx_valid;
  logic [7:0] tx_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_ticks_q    <= RedTicksRst;
      yellow_ticks_q <= YellowTicksRst;
      green_ticks_q  <= GreenTicksRst;
      blink_ticks_q  <= BlinkTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RED:    red_ticks_q    <= cfg_data_i;
        REG_YELLOW: yellow_ticks_q <= cfg_data_i;
        REG_GREEN:  green_ticks_q  <= cfg_data_i;
        REG_BLINK:  blink_ticks_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (mode_q == MODE_BLINK) begin
      len = blink_ticks_q;
    end else begin
      case (phase_q)
        PH_RED:    len = red_ticks_q;
        PH_YELLOW: len = yellow_ticks_q;
        default:   len = green_ticks_q;
      endcase
    end
  end

  assign cnt_nxt  = CmpWidth'(cnt_q) + CmpWidth'(1);
  assign len_ext  = CmpWidth'(len);
  assign cmax_ext = CmpWidth'({COUNT_WIDTH{1'b1}});

  always_comb begin
    mode_d    = mode_q;
    local_d   = local_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    req_valid = 1'b0;
    req_mode  = mode_q;
    tx_valid  = 1'b0;
    tx_byte   = 8'h00;
    case (item_i.kind)
      KIND_TICK: begin
        if (mode_q == MODE_BLINK || mode_q == MODE_CYCLE) begin
          if (cnt_nxt >= len_ext || cnt_nxt >= cmax_ext) begin
            cnt_d = '0;
            if (mode_q == MODE_BLINK) begin
              phase_d = phase_q ^ PH_DARK;
            end else begin
              phase_d = (phase_q >= PH_GREEN) ? PH_RED : phase_q + 2'd1;
            end
          end else begin
            cnt_d = cnt_nxt[COUNT_WIDTH-1:0];
          end
        end
      end
      KIND_RX: begin
        if (item_i.rx_byte == CH_LOCAL) begin
          local_d  = 1'b1;
          tx_valid = 1'b1;
          tx_byte  = CH_ACK_LOC;
        end else if (item_i.rx_byte == CH_REMOTE) begin
          local_d  = 1'b0;
          tx_valid = 1'b1;
          tx_byte  = CH_ACK_REM;
        end else if (!local_q && item_i.rx_byte inside {[CH_DIG_LO:CH_DIG_HI]}) begin
          // low bits of '1'..'3' are the mode code
          req_valid = 1'b1;
          req_mode  = item_i.rx_byte[1:0];
        end
      end
      KIND_BTN: begin
        if (local_q && item_i.button_index != BTN_NONE) begin
          req_valid = 1'b1;
          req_mode  = item_i.button_index + 2'd1;
        end
      end
      default: ;
    endcase
    if (req_valid && req_mode != mode_q) begin
      mode_d   = req_mode;
      phase_d  = PH_RED;
      cnt_d    = '0;
      tx_valid = 1'b1;
      tx_byte  = mode_reply(req_mode);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_CYCLE;
      local_q <= 1'b1;
      phase_q <= PH_RED;
      cnt_q   <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      local_q <= local_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    result_o          = '0;
    result_o.tx_valid = tx_valid;
    result_o.tx_byte  = tx_byte;
    case (mode_d)
      MODE_RED: begin
        result_o.lamp_red = 1'b1;
      end
      MODE_BLINK: begin
        result_o.lamp_yellow = (phase_d == PH_LIT);
      end
      MODE_CYCLE: begin
        result_o.lamp_red    = (phase_d == PH_RED);
        result_o.lamp_yellow = (phase_d == PH_YELLOW);
        result_o.lamp_green  = (phase_d == PH_GREEN);
      end
      default: ;
    endcase
  end

endmodule

// ===== src/traffic_light_mode_controller_core.sv =====
// Traffic light mode controller: one input item (tick, received byte or
// button press) yields exactly one result item with the lamp drive after
// that item and an optional reply byte. Items flow through an input
// register and a result register, so the block takes one item per clock
// cycle unless m_axis_tready stalls the result register; the engine state
// updates as each result is captured. The result register lets the next item
// be accepted while a finished result waits on m_axis_tready. The user must
// write phase lengths through the cfg port only while the block is idle; the
// block itself does not enforce this.
module traffic_light_mode_controller_core
  import tlmc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,  // rx_byte, button_index, zero pad
  input  logic [1:0]             s_axis_tuser,  // kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [15:0]            m_axis_tdata,  // lamp_red, lamp_yellow, lamp_green,
                                                // tx_byte, zero pad
  output logic [0:0]             m_axis_tuser   // tx_valid
);

  logic         in_v_q;
  tlmc_item_t   item_q;
  logic         out_v_q;
  tlmc_result_t res_q, res_d;
  logic         adv;

  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.kind         <= s_axis_tuser;
      item_q.rx_byte      <= s_axis_tdata[7:0];
      item_q.button_index <= s_axis_tdata[9:8];
    end
    if (adv && in_v_q) begin
      res_q <= res_d;
    end
  end

  tlmc_engine #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .fire_i    (adv && in_v_q),
    .item_i    (item_q),
    .result_o  (res_d)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, res_q.tx_byte, res_q.lamp_green,
                          res_q.lamp_yellow, res_q.lamp_red};
  assign m_axis_tuser  = res_q.tx_valid;

endmodule
